[rtl/core/mbs_pkg.sv]
package mbs_pkg;

  localparam int unsigned AdcW     = 10;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned DirW     = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Rise above the flat level that opens the charging window, compared on AdcW+1 bits
  localparam logic [AdcW:0]   RiseThreshold = (AdcW + 1)'(67);
  // Drop below the peak that ends charging
  localparam logic [AdcW-1:0] PeakDrop      = AdcW'(5);
  localparam logic [AdcW-1:0] LimitReset    = {AdcW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFT_LIMIT   = 3'd0,
    CFG_RIGHT_LIMIT  = 3'd1,
    CFG_FLAT_VOLTAGE = 3'd2,
    CFG_PEAK_MIN     = 3'd3,
    CFG_PLATEAU_MS   = 3'd4,
    CFG_TRIP_HOLD_MS = 3'd5
  } mbs_cfg_idx_e;

  typedef enum logic [DirW-1:0] {
    DIR_REVERSE = 2'd0,
    DIR_BRAKE   = 2'd1,
    DIR_FORWARD = 2'd2,
    DIR_NONE    = 2'd3
  } mbs_dir_e;

  typedef struct packed {
    logic [AdcW-1:0]  battery_level;
    logic [AdcW-1:0]  left_current;
    logic [AdcW-1:0]  right_current;
    logic [TimeW-1:0] now_ms;
    logic [DirW-1:0]  left_dir;
    logic [DutyW-1:0] left_duty;
    logic [DirW-1:0]  right_dir;
    logic [DutyW-1:0] right_duty;
  } mbs_in_t;

  typedef struct packed {
    logic             charger_disabled;
    logic [DutyW-1:0] left_a_duty;
    logic [DutyW-1:0] left_b_duty;
    logic [DutyW-1:0] right_a_duty;
    logic [DutyW-1:0] right_b_duty;
    logic             battery_good;
  } mbs_out_t;

  typedef struct packed {
    logic [AdcW-1:0]  left_current_limit;
    logic [AdcW-1:0]  right_current_limit;
    logic [AdcW-1:0]  flat_voltage;
    logic [AdcW-1:0]  peak_min_voltage;
    logic [TimeW-1:0] plateau_timeout_ms;
    logic [TimeW-1:0] trip_hold_ms;
  } mbs_cfg_t;

  // Charge controller status handed to the bridge controller and the result
  typedef struct packed {
    logic charged_mid;      // charged after the flat check, before peak end
    logic window;           // charging window: bridges hold
    logic charged_next;     // battery_good of this item
    logic charger_off_next; // charger_disabled of this item
  } mbs_chg_stat_t;

endpackage

[rtl/core/mbs_cfg_regs.sv]
module mbs_cfg_regs
  import mbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  index_i,
  input  logic [CfgDataW-1:0] data_i,
  output mbs_cfg_t            cfg_o
);

  mbs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (mbs_cfg_idx_e'(index_i))
        CFG_LEFT_LIMIT:   cfg_d.left_current_limit  = data_i[AdcW-1:0];
        CFG_RIGHT_LIMIT:  cfg_d.right_current_limit = data_i[AdcW-1:0];
        CFG_FLAT_VOLTAGE: cfg_d.flat_voltage        = data_i[AdcW-1:0];
        CFG_PEAK_MIN:     cfg_d.peak_min_voltage    = data_i[AdcW-1:0];
        CFG_PLATEAU_MS:   cfg_d.plateau_timeout_ms  = data_i[TimeW-1:0];
        CFG_TRIP_HOLD_MS: cfg_d.trip_hold_ms        = data_i[TimeW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_current_limit  <= LimitReset;
      cfg_q.right_current_limit <= LimitReset;
      cfg_q.flat_voltage        <= '0;
      cfg_q.peak_min_voltage    <= '0;
      cfg_q.plateau_timeout_ms  <= '0;
      cfg_q.trip_hold_ms        <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/mbs_charge_ctrl.sv]
module mbs_charge_ctrl
  import mbs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  mbs_in_t       item_i,
  input  mbs_cfg_t      cfg_i,
  output mbs_chg_stat_t stat_o
);

  logic             charged_q, charged_d;
  logic             charger_off_q, charger_off_d;
  logic [AdcW-1:0]  peak_q, peak_d;
  logic [AdcW-1:0]  flat_start_q, flat_start_d;
  logic [TimeW-1:0] last_rise_q, last_rise_d;

  logic             go_flat;
  logic             charged_mid;
  logic             window;
  logic [AdcW-1:0]  peak_mid;
  logic [TimeW-1:0] rise_mid;
  logic             dropped;
  logic             stalled;

  always_comb begin
    go_flat      = (item_i.battery_level < cfg_i.flat_voltage) && charged_q;
    charged_mid  = charged_q && !go_flat;
    peak_mid     = go_flat ? item_i.battery_level : peak_q;
    flat_start_d = go_flat ? item_i.battery_level : flat_start_q;
    rise_mid     = go_flat ? item_i.now_ms : last_rise_q;

    window = !charged_mid &&
             ({1'b0, item_i.battery_level} > ({1'b0, flat_start_d} + RiseThreshold));

    peak_d        = peak_mid;
    last_rise_d   = rise_mid;
    charged_d     = charged_mid;
    charger_off_d = go_flat ? 1'b0 : charger_off_q;

    if (window) begin
      // Track the peak; a new peak restarts the plateau timer
      if (item_i.battery_level > peak_mid) begin
        peak_d      = item_i.battery_level;
        last_rise_d = item_i.now_ms;
      end
    end

    // Within the window peak_d never lies below the level, so the unsigned drop is exact
    dropped = (peak_d - item_i.battery_level) > PeakDrop;
    stalled = (item_i.now_ms - last_rise_d) > cfg_i.plateau_timeout_ms;

    if (window && (item_i.battery_level > cfg_i.peak_min_voltage) && (dropped || stalled)) begin
      charged_d     = 1'b1;
      charger_off_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charged_q     <= 1'b1;
      charger_off_q <= 1'b1;
      peak_q        <= '0;
      flat_start_q  <= '0;
      last_rise_q   <= '0;
    end else if (advance_i) begin
      charged_q     <= charged_d;
      charger_off_q <= charger_off_d;
      peak_q        <= peak_d;
      flat_start_q  <= flat_start_d;
      last_rise_q   <= last_rise_d;
    end
  end

  assign stat_o.charged_mid      = charged_mid;
  assign stat_o.window           = window;
  assign stat_o.charged_next     = charged_d;
  assign stat_o.charger_off_next = charger_off_d;

endmodule

[rtl/core/mbs_bridge_ctrl.sv]
module mbs_bridge_ctrl
  import mbs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  mbs_in_t               item_i,
  input  mbs_cfg_t              cfg_i,
  input  mbs_chg_stat_t         chg_i,
  output logic [3:0][DutyW-1:0] duties_o
);

  logic [3:0][DutyW-1:0] duty_q, duty_d, duty_trip;
  logic [TimeW-1:0]      ltrip_q, ltrip_d;
  logic [TimeW-1:0]      rtrip_q, rtrip_d;
  logic                  ltrip, rtrip;
  logic                  lhold_done, rhold_done;

  // Side A in element 0, side B in element 1
  function automatic logic [1:0][DutyW-1:0] drive(input logic [DirW-1:0] dir,
                                                  input logic [DutyW-1:0] duty,
                                                  input logic [1:0][DutyW-1:0] cur);
    logic [1:0][DutyW-1:0] res;
    res = cur;
    unique case (mbs_dir_e'(dir))
      DIR_FORWARD: begin res[0] = '0;   res[1] = duty; end
      DIR_BRAKE:   begin res[0] = duty; res[1] = duty; end
      DIR_REVERSE: begin res[0] = duty; res[1] = '0;   end
      default:     res = cur;
    endcase
    return res;
  endfunction

  always_comb begin
    ltrip   = item_i.left_current > cfg_i.left_current_limit;
    rtrip   = item_i.right_current > cfg_i.right_current_limit;
    ltrip_d = ltrip ? item_i.now_ms : ltrip_q;
    rtrip_d = rtrip ? item_i.now_ms : rtrip_q;

    duty_trip = duty_q;
    if (ltrip) begin
      duty_trip[0] = '0;
      duty_trip[1] = '0;
    end
    if (rtrip) begin
      duty_trip[2] = '0;
      duty_trip[3] = '0;
    end

    // A trip on this item gives a zero difference and never passes the hold
    lhold_done = (item_i.now_ms - ltrip_d) > cfg_i.trip_hold_ms;
    rhold_done = (item_i.now_ms - rtrip_d) > cfg_i.trip_hold_ms;

    duty_d = duty_trip;
    if (chg_i.window) begin
      duty_d = duty_trip;
    end else if (chg_i.charged_mid) begin
      if (lhold_done) begin
        duty_d[1:0] = drive(item_i.left_dir, item_i.left_duty, duty_trip[1:0]);
      end
      if (rhold_done) begin
        duty_d[3:2] = drive(item_i.right_dir, item_i.right_duty, duty_trip[3:2]);
      end
    end else begin
      duty_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q  <= '0;
      ltrip_q <= '0;
      rtrip_q <= '0;
    end else if (advance_i) begin
      duty_q  <= duty_d;
      ltrip_q <= ltrip_d;
      rtrip_q <= rtrip_d;
    end
  end

  assign duties_o = duty_d;

endmodule

[rtl/core/motor_battery_supervisor_unit.sv]
// Battery and dual H-bridge supervisor, one supervision tick per input item.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one tick carries the
// battery and both motor-current ADC samples, the millisecond time and the
// direction and duty command of each motor. Output channel (out_valid_o /
// out_stall_i / out_item_o): exactly one result per tick with the charger
// control, the four bridge duties and the battery state.
// Config channel (cfg_valid_i / cfg_ready_o): cfg_index_i selects the
// register, cfg_data_i is masked to the register width; indexes 6 and 7
// are dropped. ready is always high. Write only while no tick is in flight.
//
// The tick is captured in the input register, then the whole update (trip
// compare, flat and peak detection, bridge drive) runs in one pass into the
// result register. Throughput is one tick per cycle while out_stall_i is low.
// Reset clears both stage valid bits; the battery reads charged, the charger
// is off, trip and rise times are zero and all bridge duties are zero.
// A stalled result holds in the output register; one more tick is taken into
// the input register, after which in_stall_o rises until the result drains.
module motor_battery_supervisor_unit
  import mbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mbs_in_t             in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mbs_out_t            out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic                  s1_valid_q, s1_valid_d;
  mbs_in_t               s1_item_q;
  logic                  out_valid_q, out_valid_d;
  mbs_out_t              out_item_q, out_item_d;
  logic                  out_free;
  logic                  advance;
  logic                  in_accept;
  mbs_cfg_t              cfg;
  mbs_chg_stat_t         chg_stat;
  logic [3:0][DutyW-1:0] duties;

  assign cfg_ready_o = 1'b1;

  // Advance the captured tick whenever the result register is empty or draining
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  mbs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  mbs_charge_ctrl u_charge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_item_q),
    .cfg_i     (cfg),
    .stat_o    (chg_stat)
  );

  mbs_bridge_ctrl u_bridge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_item_q),
    .cfg_i     (cfg),
    .chg_i     (chg_stat),
    .duties_o  (duties)
  );

  always_comb begin
    out_item_d.charger_disabled = chg_stat.charger_off_next;
    out_item_d.left_a_duty      = duties[0];
    out_item_d.left_b_duty      = duties[1];
    out_item_d.right_a_duty     = duties[2];
    out_item_d.right_b_duty     = duties[3];
    out_item_d.battery_good     = chg_stat.charged_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on capture, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[rtl/core/mbs_checker.sv]
module mbs_checker
  import mbs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input mbs_in_t             in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input mbs_out_t            out_item_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Stall the input only when a result is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // The charger runs exactly while the battery is flat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.charger_disabled == out_item_o.battery_good)
    else $error("charger state disagrees with battery state");

  // Both sides of a bridge driven only as brake with equal duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.left_a_duty != '0 && out_item_o.left_b_duty != '0 |->
      out_item_o.left_a_duty == out_item_o.left_b_duty)
    else $error("left bridge drives both sides unequally");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.right_a_duty != '0 && out_item_o.right_b_duty != '0 |->
      out_item_o.right_a_duty == out_item_o.right_b_duty)
    else $error("right bridge drives both sides unequally");

endmodule

bind motor_battery_supervisor_unit mbs_checker u_mbs_checker (.*);
